### design/lgge_pkg.sv
`timescale 1ns / 1ps

package lgge_pkg;

    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 64;

    localparam int KIND_W  = 2;
    localparam int COORD_W = 6;

    localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;

endpackage

### design/life_grid_generation_engine.sv
`timescale 1ns / 1ps

// life grid engine, rule b3/s23, on a grid of GRID_WIDTH x GRID_HEIGHT cells
// input channel s_*: one word per operation (write cell, read cell, advance a
// generation); result channel m_*: exactly one word per input word, in order
// sequence: write, read and the unused kind pass through the access state and
// the done state before m_valid rises; advance passes through the generation
// state, where the row sequencer streams one row per cycle through the read
// port of the row memory and writes the new row two rows behind through the
// write port, and then the done state; no new input word is accepted until
// the previous result has gone to the output register
// reset: aresetn low synchronously; afterwards a clearing pass writes every
// row dead, and s_ready stays low until it ends
// stall: a finished word waits in the output register while the next input
// word is accepted; a further result waits inside the block until the output
// register drains, and s_ready stays low meanwhile
// cells outside the grid are dead; writes outside it are dropped and reads
// there return 0
module life_grid_generation_engine #(
    parameter int GRID_WIDTH  = lgge_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = lgge_pkg::GRID_HEIGHT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [lgge_pkg::KIND_W-1:0]  s_kind,
    input  logic [lgge_pkg::COORD_W-1:0] s_col,
    input  logic [lgge_pkg::COORD_W-1:0] s_row,
    input  logic                         s_live_in,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_cell_live,
    output logic                         m_done_res
);
    import lgge_pkg::*;

    localparam int CW   = $clog2(GRID_WIDTH);
    localparam int RW   = $clog2(GRID_HEIGHT);
    localparam int CNTW = $clog2(GRID_HEIGHT + 2);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_ACCESS = 5'b00100,
        ST_GEN    = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    typedef logic [GRID_WIDTH-1:0] row_t;

    function automatic row_t next_row(input row_t up, input row_t cur, input row_t dn);
        logic [GRID_WIDTH+1:0] up_p;
        logic [GRID_WIDTH+1:0] cur_p;
        logic [GRID_WIDTH+1:0] dn_p;
        logic [3:0]            n;
        row_t                  res;
        up_p  = {1'b0, up, 1'b0};
        cur_p = {1'b0, cur, 1'b0};
        dn_p  = {1'b0, dn, 1'b0};
        res   = '0;
        for (int c = 0; c < GRID_WIDTH; c++) begin
            n = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
              + 4'(cur_p[c]) + 4'(cur_p[c+2])
              + 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
            res[c] = cur[c] ? (n == 4'd2 || n == 4'd3) : (n == 4'd3);
        end
        return res;
    endfunction

    state_t          state_reg, state_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic            live_reg, live_next;
    logic            in_grid_reg, in_grid_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    row_t            up_reg, up_next;
    row_t            cur_reg, cur_next;
    logic            res_reg, res_next;
    logic            m_valid_reg, m_valid_next;
    logic            m_live_reg, m_live_next;

    row_t            mem [GRID_HEIGHT];
    row_t            rd_data_reg;
    logic            mem_we;
    logic [RW-1:0]   mem_waddr;
    row_t            mem_wdata;
    logic            mem_re;
    logic [RW-1:0]   mem_raddr;

    logic            in_grid;
    logic            s_fire;
    logic            out_free;
    logic [CNTW-1:0] cnt_inc;
    logic [CNTW-1:0] cnt_dec;
    row_t            down;
    row_t            mod_row;

    assign s_ready     = (state_reg == ST_IDLE);
    assign s_fire      = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_cell_live = m_live_reg;
    assign m_done_res  = 1'b1;
    assign out_free    = !m_valid_reg || m_ready;

    assign in_grid = ({1'b0, s_col} < 7'(GRID_WIDTH))
                  && ({26'd0, s_row} < 32'(GRID_HEIGHT));

    assign cnt_inc = cnt_reg + CNTW'(1);
    assign cnt_dec = cnt_reg - CNTW'(1);
    assign down    = (cnt_reg < CNTW'(GRID_HEIGHT)) ? rd_data_reg : '0;

    always_comb begin
        mod_row          = rd_data_reg;
        mod_row[col_reg] = live_reg;
    end

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        live_next    = live_reg;
        in_grid_next = in_grid_reg;
        cnt_next     = cnt_reg;
        up_next      = up_reg;
        cur_next     = cur_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_live_next  = m_live_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[RW-1:0];
                cnt_next  = cnt_inc;
                if (cnt_reg == CNTW'(GRID_HEIGHT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    kind_next    = s_kind;
                    col_next     = CW'(s_col);
                    row_next     = RW'(s_row);
                    live_next    = s_live_in;
                    in_grid_next = in_grid;
                    cnt_next     = '0;
                    if (s_kind == KIND_ADVANCE) begin
                        mem_re     = 1'b1;
                        state_next = ST_GEN;
                    end else begin
                        mem_re     = in_grid;
                        mem_raddr  = RW'(s_row);
                        state_next = ST_ACCESS;
                    end
                end
            end
            ST_ACCESS: begin
                res_next = 1'b0;
                if (kind_reg == KIND_WRITE && in_grid_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = row_reg;
                    mem_wdata = mod_row;
                end
                if (kind_reg == KIND_READ && in_grid_reg) begin
                    res_next = rd_data_reg[col_reg];
                end
                state_next = ST_DONE;
            end
            ST_GEN: begin
                res_next = 1'b0;
                if (cnt_inc < CNTW'(GRID_HEIGHT)) begin
                    mem_re    = 1'b1;
                    mem_raddr = cnt_inc[RW-1:0];
                end
                if (cnt_reg == '0) begin
                    up_next  = '0;
                    cur_next = rd_data_reg;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_dec[RW-1:0];
                    mem_wdata = next_row(up_reg, cur_reg, down);
                    up_next   = cur_reg;
                    cur_next  = down;
                end
                cnt_next = cnt_inc;
                if (cnt_reg == CNTW'(GRID_HEIGHT)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_live_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        live_reg    <= live_next;
        in_grid_reg <= in_grid_next;
        up_reg      <= up_next;
        cur_reg     <= cur_next;
        res_reg     <= res_next;
        m_live_reg  <= m_live_next;
    end

    // row memory, one write port and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule
